// ===== sv/sfd_pkg.sv =====
package sfd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int DELAY_BITS  = 16;
   localparam int GAIN_BITS   = 9;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int ACC_BITS    = SAMPLE_BITS + 12;
   localparam int FRAC_BITS   = 8;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic [GAIN_BITS-1:0]          gain_type;

   localparam acc_type ACC_SMAX  = ACC_BITS'((2**(SAMPLE_BITS-1)) - 1);
   localparam acc_type ACC_SMIN  = -ACC_SMAX - ACC_BITS'(1);
   localparam acc_type ACC_ROUND = ACC_BITS'(2**(FRAC_BITS-1));
   localparam logic signed [GAIN_BITS:0] UNITY = (GAIN_BITS+1)'(2**FRAC_BITS);

   localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(24000);
   localparam gain_type GAIN_RESET = GAIN_BITS'(77);
   localparam gain_type MIX_RESET  = GAIN_BITS'(256);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY = 2'd0,
      CSR_GAIN  = 2'd1,
      CSR_MIX   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WET,
      ST_FB,
      ST_MIX
   } state_type;

   typedef struct packed {
      logic [DELAY_BITS-1:0] delay_samples;
      gain_type              feedback_gain;
      gain_type              mix_level;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic read;
      logic wet;
      logic fb;
      logic finish;
   } cmd_type;

   function automatic acc_type scale_round(input acc_type p);
      acc_type q;
      q = p + ACC_ROUND;
      return q >>> FRAC_BITS;
   endfunction

   function automatic sample_type saturate(input acc_type v);
      acc_type r;
      if (v > ACC_SMAX) begin
         r = ACC_SMAX;
      end else if (v < ACC_SMIN) begin
         r = ACC_SMIN;
      end else begin
         r = v;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

endpackage

// ===== sv/sfd_csr.sv =====
module sfd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output sfd_pkg::cfg_type                 cfg
);
   import sfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DELAY: cfg_in.delay_samples = DELAY_BITS'(csr_data);
            CSR_GAIN:  cfg_in.feedback_gain = csr_data[GAIN_BITS-1:0];
            CSR_MIX:   cfg_in.mix_level     = csr_data[GAIN_BITS-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_samples <= DELAY_RESET;
         cfg_ff.feedback_gain <= GAIN_RESET;
         cfg_ff.mix_level     <= MIX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/sfd_ctrl.sv =====
module sfd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfd_pkg::cmd_type cmd
);
   import sfd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_WET;
         end
         ST_WET: begin
            cmd.wet  = 1'b1;
            state_in = ST_FB;
         end
         ST_FB: begin
            cmd.fb   = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/sfd_datapath.sv =====
module sfd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sfd_pkg::cmd_type    cmd,
   input  sfd_pkg::cfg_type    cfg,
   input  sfd_pkg::sample_type req_left_in,
   input  sfd_pkg::sample_type req_right_in,
   output sfd_pkg::sample_type rsp_left_out,
   output sfd_pkg::sample_type rsp_right_out
);
   import sfd_pkg::*;

   sample_type left_mem  [STORE_DEPTH];
   sample_type right_mem [STORE_DEPTH];

   addr_type   wp_ff;
   addr_type   wp_in;
   logic       wrapped_ff;
   logic       wrapped_in;
   addr_type   rp_ff;
   logic       zero_ff;
   logic       written_ff;
   addr_type   dl_mod;
   addr_type   rp_in;

   sample_type x_ff   [2];
   sample_type rd_ff  [2];
   sample_type wet_ff [2];
   sample_type fb_ff  [2];
   prod_type   dry_ff [2];
   sample_type out_ff [2];

   sample_type d_eff    [2];
   prod_type   gd_prod  [2];
   prod_type   gw_prod  [2];
   prod_type   mw_prod  [2];
   prod_type   dry_prod [2];
   sample_type wet_in   [2];
   sample_type fb_in    [2];
   sample_type out_in   [2];

   logic signed [GAIN_BITS:0] gain_s;
   logic signed [GAIN_BITS:0] mix_s;
   logic signed [GAIN_BITS:0] dry_w;

   assign rsp_left_out  = out_ff[0];
   assign rsp_right_out = out_ff[1];

   assign dl_mod = ADDR_BITS'(cfg.delay_samples);
   assign rp_in  = wp_ff - dl_mod;
   assign gain_s = $signed({1'b0, cfg.feedback_gain});
   assign mix_s  = $signed({1'b0, cfg.mix_level});
   assign dry_w  = UNITY - mix_s;
   assign wp_in  = wp_ff + ADDR_BITS'(1);
   assign wrapped_in = wrapped_ff || (wp_in == '0);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (zero_ff) begin
            d_eff[i] = x_ff[i];
         end else if (written_ff) begin
            d_eff[i] = rd_ff[i];
         end else begin
            d_eff[i] = '0;
         end
         gd_prod[i]  = PROD_BITS'(gain_s) * PROD_BITS'(d_eff[i]);
         wet_in[i]   = saturate(ACC_BITS'(x_ff[i]) + scale_round(ACC_BITS'(gd_prod[i])));
         gw_prod[i]  = PROD_BITS'(gain_s) * PROD_BITS'(wet_ff[i]);
         fb_in[i]    = saturate(ACC_BITS'(x_ff[i]) + scale_round(ACC_BITS'(gw_prod[i])));
         dry_prod[i] = PROD_BITS'(dry_w) * PROD_BITS'(x_ff[i]);
         mw_prod[i]  = PROD_BITS'(mix_s) * PROD_BITS'(wet_ff[i]);
         out_in[i]   = saturate(scale_round(ACC_BITS'(dry_ff[i]) + ACC_BITS'(mw_prod[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else if (cmd.finish) begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff[0]    <= req_left_in;
         x_ff[1]    <= req_right_in;
         rp_ff      <= rp_in;
         zero_ff    <= (dl_mod == '0);
         written_ff <= wrapped_ff || (rp_in < wp_ff);
      end
      if (cmd.wet) begin
         wet_ff <= wet_in;
      end
      if (cmd.fb) begin
         fb_ff  <= fb_in;
         dry_ff <= dry_prod;
      end
      if (cmd.finish) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_ff[0] <= left_mem[rp_ff];
         rd_ff[1] <= right_mem[rp_ff];
      end
      if (cmd.finish) begin
         left_mem[wp_ff]  <= fb_ff[0];
         right_mem[wp_ff] <= fb_ff[1];
      end
   end

endmodule

// ===== sv/stereo_feedback_delay_mix_core.sv =====
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_left_in, req_right_in
// rsp       out        rsp_valid, rsp_ready, rsp_left_out, rsp_right_out
// csr       in         csr_valid, csr_ready, csr_index, csr_data
//
// A frame's result is registered as the controller's walk of delay read, wet product, feedback and
// dry product, and mix with write-back ends, and the next frame is accepted only once that walk
// has returned to idle.
// Reset is synchronous; it clears the controller and write pointer, sets configuration defaults, and
// entries not yet written since reset read as zero through a wrap flag, so no clearing pass is needed.
// A result waiting on rsp_ready does not block the next accepting beat; it holds the following
// frame in its mix step until the result beat is taken.
module stereo_feedback_delay_mix_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sfd_pkg::sample_type         req_left_in,
   input  sfd_pkg::sample_type         req_right_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sfd_pkg::sample_type         rsp_left_out,
   output sfd_pkg::sample_type         rsp_right_out,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import sfd_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   sfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sfd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

// ===== sv/sfd_checker.sv =====
module sfd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input sfd_pkg::sample_type rsp_left_out,
   input sfd_pkg::sample_type rsp_right_out
);
   import sfd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out))
      else $error("result beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=>
         !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input beat taken before the previous frame finished");

   a_result_on_return: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $rose(req_ready) |-> rsp_valid)
      else $error("frame finished without a result beat");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && req_ready |=> !rsp_valid)
      else $error("result beat appeared without a frame finishing");

endmodule

bind stereo_feedback_delay_mix_core sfd_checker u_sfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);
